>>> hdl/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants for the dashed DDA line rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

	localparam int COORD_BITS = 12;
	localparam int DASH_BITS  = 8;
	localparam int CFG_IDX_W  = 2;

	// Function codes of an input item.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DASH_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DASH_PERIOD    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DASH_ON_LENGTH = 2'd2;

	// Configuration reset values.
	localparam logic                 DASH_ENABLE_RST    = 1'b0;
	localparam logic [DASH_BITS-1:0] DASH_PERIOD_RST    = 8'd10;
	localparam logic [DASH_BITS-1:0] DASH_ON_LENGTH_RST = 8'd5;

	typedef struct packed {
		logic                   func;
		logic [COORD_BITS-1:0]  start_x;
		logic [COORD_BITS-1:0]  start_y;
		logic [COORD_BITS-1:0]  end_x;
		logic [COORD_BITS-1:0]  end_y;
	} item_t;

	typedef struct packed {
		logic                   point_valid;
		logic [COORD_BITS-1:0]  pixel_x;
		logic [COORD_BITS-1:0]  pixel_y;
		logic                   visible;
		logic                   last_point;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // latch endpoints, start the dividers
		logic step;      // produce one point into the result register
		logic div_step;  // one quotient bit per divider
		logic finish;    // latch the signed increments
	} dp_cmd_t;

endpackage

>>> hdl/dda_div.sv
// ----------------------------------------------------------------------------
// dda_div
// Restoring divider, one quotient bit per cycle while step is high, for numerator <= divisor.
// ----------------------------------------------------------------------------
module dda_div #(
	parameter int NUM_W = 12,
	parameter int QUO_W = 17
) (
	input  logic             clk,
	input  logic             start,
	input  logic             step,
	input  logic [NUM_W-1:0] num,
	input  logic [NUM_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	logic [NUM_W:0]   rem_q;
	logic [NUM_W-1:0] den_q;
	logic [QUO_W-1:0] quo_q;
	logic [NUM_W:0]   diff;
	logic [NUM_W:0]   rem_next;
	logic             ge;

	always_comb begin
		ge       = (rem_q >= {1'b0, den_q});
		diff     = rem_q - {1'b0, den_q};
		rem_next = ge ? diff : rem_q;
	end

	// The first step weighs the unshifted numerator, so it yields the integer bit.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (step) begin
			rem_q <= {rem_next[NUM_W-1:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign quo = quo_q;

endmodule

>>> hdl/dda_ctrl.sv
// ----------------------------------------------------------------------------
// dda_ctrl
// Handshake and sequencing controller for the line rasterizer.
// ----------------------------------------------------------------------------
module dda_ctrl #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_func,
	output logic              item_stall,
	output logic              result_valid,
	input  logic              result_stall,
	output dda_pkg::dp_cmd_t  cmd
);

	localparam int CNT_W = $clog2(FRAC_BITS + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

	dda_pkg::state_t  state_q;
	dda_pkg::state_t  state_next;
	logic [CNT_W-1:0] cnt_q;
	logic             result_valid_q;
	logic             accept;

	assign item_stall = (state_q != dda_pkg::ST_IDLE) || (result_valid_q && result_stall);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		state_next = state_q;
		case (state_q)
			dda_pkg::ST_IDLE: begin
				if (accept && item_func == dda_pkg::FUNC_LOAD)
					state_next = dda_pkg::ST_DIVIDE;
			end
			dda_pkg::ST_DIVIDE: begin
				if (cnt_q == CNT_LAST)
					state_next = dda_pkg::ST_FINISH;
			end
			dda_pkg::ST_FINISH: begin
				state_next = dda_pkg::ST_IDLE;
			end
			default: begin
				state_next = dda_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = accept && (item_func == dda_pkg::FUNC_LOAD);
		cmd.step     = accept && (item_func == dda_pkg::FUNC_STEP);
		cmd.div_step = (state_q == dda_pkg::ST_DIVIDE);
		cmd.finish   = (state_q == dda_pkg::ST_FINISH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= dda_pkg::ST_IDLE;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.step)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;

endmodule

>>> hdl/dda_dp.sv
// ----------------------------------------------------------------------------
// dda_dp
// Datapath: endpoint setup, increment dividers, position stepping and dashing.
// ----------------------------------------------------------------------------
module dda_dp #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dda_pkg::dp_cmd_t                cmd,
	input  dda_pkg::item_t                  item,
	input  logic                            cfg_write_en,
	input  logic [dda_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dda_pkg::DASH_BITS-1:0]   cfg_data,
	output dda_pkg::result_t                result
);

	localparam int C     = dda_pkg::COORD_BITS;
	localparam int D     = dda_pkg::DASH_BITS;
	localparam int POS_W = C + FRAC_BITS + 1;
	localparam int INC_W = FRAC_BITS + 2;
	localparam int QUO_W = FRAC_BITS + 1;
	localparam logic [POS_W-1:0] HALF =
		{{(POS_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

	// Configuration registers.
	logic         dash_enable_q;
	logic [D-1:0] dash_period_q;
	logic [D-1:0] dash_on_length_q;

	// Line state.
	logic [POS_W-1:0] x_pos_q;
	logic [POS_W-1:0] y_pos_q;
	logic [INC_W-1:0] x_inc_q;
	logic [INC_W-1:0] y_inc_q;
	logic [C:0]       points_left_q;
	logic [D-1:0]     phase_q;
	logic             active_q;
	logic             x_neg_q;
	logic             y_neg_q;
	logic             zero_len_q;
	dda_pkg::result_t result_q;

	// Setup logic.
	logic [C:0]   dx;
	logic [C:0]   dy;
	logic [C:0]   adx_full;
	logic [C:0]   ady_full;
	logic [C-1:0] adx;
	logic [C-1:0] ady;
	logic [C-1:0] steps;
	logic [QUO_W-1:0] x_quo;
	logic [QUO_W-1:0] y_quo;
	logic [INC_W-1:0] x_mag;
	logic [INC_W-1:0] y_mag;

	// Step logic.
	logic [POS_W-1:0] x_round;
	logic [POS_W-1:0] y_round;
	logic [D:0]       phase_inc;
	logic             phase_wrap;

	always_comb begin
		dx       = {item.end_x[C-1], item.end_x} - {item.start_x[C-1], item.start_x};
		dy       = {item.end_y[C-1], item.end_y} - {item.start_y[C-1], item.start_y};
		adx_full = dx[C] ? (~dx + 1'b1) : dx;
		ady_full = dy[C] ? (~dy + 1'b1) : dy;
		adx      = adx_full[C-1:0];
		ady      = ady_full[C-1:0];
		steps    = (adx > ady) ? adx : ady;
	end

	dda_div #(.NUM_W(C), .QUO_W(QUO_W)) u_div_x (
		.clk   (clk),
		.start (cmd.load),
		.step  (cmd.div_step),
		.num   (adx),
		.den   (steps),
		.quo   (x_quo)
	);

	dda_div #(.NUM_W(C), .QUO_W(QUO_W)) u_div_y (
		.clk   (clk),
		.start (cmd.load),
		.step  (cmd.div_step),
		.num   (ady),
		.den   (steps),
		.quo   (y_quo)
	);

	always_comb begin
		x_mag      = {1'b0, x_quo};
		y_mag      = {1'b0, y_quo};
		x_round    = x_pos_q + HALF;
		y_round    = y_pos_q + HALF;
		phase_inc  = {1'b0, phase_q} + 1'b1;
		phase_wrap = (dash_period_q != '0) && (phase_inc >= {1'b0, dash_period_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dash_enable_q    <= dda_pkg::DASH_ENABLE_RST;
			dash_period_q    <= dda_pkg::DASH_PERIOD_RST;
			dash_on_length_q <= dda_pkg::DASH_ON_LENGTH_RST;
			x_pos_q          <= '0;
			y_pos_q          <= '0;
			x_inc_q          <= '0;
			y_inc_q          <= '0;
			points_left_q    <= '0;
			phase_q          <= '0;
			active_q         <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					dda_pkg::CFG_DASH_ENABLE:    dash_enable_q    <= cfg_data[0];
					dda_pkg::CFG_DASH_PERIOD:    dash_period_q    <= cfg_data;
					dda_pkg::CFG_DASH_ON_LENGTH: dash_on_length_q <= cfg_data;
					default: ;
				endcase
			end

			if (cmd.load) begin
				x_pos_q       <= {item.start_x[C-1], item.start_x, {FRAC_BITS{1'b0}}};
				y_pos_q       <= {item.start_y[C-1], item.start_y, {FRAC_BITS{1'b0}}};
				points_left_q <= {1'b0, steps} + 1'b1;
				phase_q       <= '0;
				active_q      <= 1'b1;
			end else if (cmd.step && active_q) begin
				x_pos_q       <= x_pos_q + {{(POS_W-INC_W){x_inc_q[INC_W-1]}}, x_inc_q};
				y_pos_q       <= y_pos_q + {{(POS_W-INC_W){y_inc_q[INC_W-1]}}, y_inc_q};
				points_left_q <= points_left_q - 1'b1;
				phase_q       <= phase_wrap ? '0 : phase_inc[D-1:0];
				if (points_left_q == {{C{1'b0}}, 1'b1})
					active_q <= 1'b0;
			end

			// A zero-length line would divide zero by zero; its increments are set to zero.
			if (cmd.finish) begin
				if (zero_len_q) begin
					x_inc_q <= '0;
					y_inc_q <= '0;
				end else begin
					x_inc_q <= x_neg_q ? (~x_mag + 1'b1) : x_mag;
					y_inc_q <= y_neg_q ? (~y_mag + 1'b1) : y_mag;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_neg_q    <= dx[C];
			y_neg_q    <= dy[C];
			zero_len_q <= (steps == '0);
		end
		if (cmd.step) begin
			if (active_q) begin
				result_q.point_valid <= 1'b1;
				result_q.pixel_x     <= x_round[FRAC_BITS+C-1:FRAC_BITS];
				result_q.pixel_y     <= y_round[FRAC_BITS+C-1:FRAC_BITS];
				result_q.visible     <= !dash_enable_q || (phase_q < dash_on_length_q);
				result_q.last_point  <= (points_left_q == {{C{1'b0}}, 1'b1});
			end else begin
				result_q <= '0;
			end
		end
	end

	assign result = result_q;

endmodule

>>> hdl/dda_dashed_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_dashed_line_rasterizer
// DDA line rasterizer with a configurable dash pattern, top level.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                Beat
//  --------  -------------------------------------  --------------------------
//  item      item_valid / item_stall / item         load (func 0) or step
//  result    result_valid / result_stall / result   one point per step beat
//  config    cfg_write_en / cfg_index / cfg_data    register write, no handshake
//
//  A step beat's point sits in the result register in the cycle after the beat
//  is taken, so points stream at one per cycle while result is taken.
//  A load beat starts the two iterative dividers, one quotient bit per cycle;
//  item_stall stays high through the divide and finish states after it, and a
//  load gives no result. item_stall also rises while a finished point waits
//  under result_stall. Reset clears the line state and sets the dash registers
//  to disabled, period 10 and on-length 5.
//
module dda_dashed_line_rasterizer #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  dda_pkg::item_t                  item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output dda_pkg::result_t                result,
	input  logic                            cfg_write_en,
	input  logic [dda_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dda_pkg::DASH_BITS-1:0]   cfg_data
);

	dda_pkg::dp_cmd_t cmd;

	dda_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_func    (item.func),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	dda_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result       (result)
	);

endmodule

>>> verif/dda_dashed_line_rasterizer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dda_dashed_line_rasterizer_test
// Self-checking bench for the dashed DDA line rasterizer. Item beats come from
// a backlog that the stimulus process fills; a predictor traces every accepted
// beat and queues any point it must cause, and the monitor compares each
// result beat with the oldest queued point. Both sides idle at random.
// ----------------------------------------------------------------------------
module dda_dashed_line_rasterizer_test;

	localparam int FRAC_BITS = 16;
	localparam int COORD_BITS = dda_pkg::COORD_BITS;
	localparam int DASH_BITS = dda_pkg::DASH_BITS;
	localparam int CFG_IDX_W = dda_pkg::CFG_IDX_W;
	localparam int POS_W = COORD_BITS + FRAC_BITS + 1;
	localparam int INC_W = FRAC_BITS + 2;
	localparam int SETTLE_CYCLES = FRAC_BITS + 14;
	localparam int LONG_HOLD_CYCLES = 150;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int REPORT_LIMIT = 100;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	dda_pkg::item_t       item = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	dda_pkg::result_t     result;
	logic                 cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DASH_BITS-1:0] cfg_data = '0;

	dda_dashed_line_rasterizer #(
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor copy of the dash registers and the line state.
	logic                        dash_en_cfg = dda_pkg::DASH_ENABLE_RST;
	logic [DASH_BITS-1:0]        dash_per_cfg = dda_pkg::DASH_PERIOD_RST;
	logic [DASH_BITS-1:0]        dash_on_cfg = dda_pkg::DASH_ON_LENGTH_RST;
	logic signed [POS_W-1:0]     pos_x = '0;
	logic signed [POS_W-1:0]     pos_y = '0;
	logic signed [INC_W-1:0]     inc_x = '0;
	logic signed [INC_W-1:0]     inc_y = '0;
	logic [COORD_BITS:0]         points_to_go = '0;
	logic [DASH_BITS-1:0]        dash_count = '0;
	logic                        line_live = 1'b0;

	dda_pkg::item_t   item_backlog[$];
	dda_pkg::result_t expected_points[$];
	int      mismatches = 0;
	int      gap_pct = 0;
	int      stall_pct = 0;
	bit      long_hold_req = 1'b0;
	bit      offering;
	int      sender_gap = 0;
	int      receiver_hold = 0;
	int      cycle_count = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap(input int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(5, 30);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [COORD_BITS-1:0] round_to_pixel(input longint pos);
		longint v;
		v = pos + (64'sd1 <<< (FRAC_BITS - 1));
		return COORD_BITS'(v >>> FRAC_BITS);
	endfunction

	function automatic int line_steps(input logic [COORD_BITS-1:0] sx, sy, ex, ey);
		int dx, dy;
		dx = int'($signed(ex));
		dx = dx - int'($signed(sx));
		dy = int'($signed(ey));
		dy = dy - int'($signed(sy));
		if (dx < 0)
			dx = -dx;
		if (dy < 0)
			dy = -dy;
		return (dx > dy) ? dx : dy;
	endfunction

	// Works out what one accepted item beat does to the line state and queues
	// the point it causes, if any.
	function automatic void trace_line_item(input dda_pkg::item_t it);
		dda_pkg::result_t pt;
		longint sx, sy, dx, dy, steps, qx, qy;
		logic [DASH_BITS:0] next_count;
		pt = '0;
		if (it.func == dda_pkg::FUNC_LOAD) begin
			sx = longint'($signed(it.start_x));
			sy = longint'($signed(it.start_y));
			dx = longint'($signed(it.end_x));
			dx = dx - sx;
			dy = longint'($signed(it.end_y));
			dy = dy - sy;
			steps = longint'(line_steps(it.start_x, it.start_y, it.end_x, it.end_y));
			qx = (steps == 0) ? 0 : (((dx < 0) ? -dx : dx) <<< FRAC_BITS) / steps;
			qy = (steps == 0) ? 0 : (((dy < 0) ? -dy : dy) <<< FRAC_BITS) / steps;
			inc_x = INC_W'((dx < 0) ? -qx : qx);
			inc_y = INC_W'((dy < 0) ? -qy : qy);
			pos_x = POS_W'(sx <<< FRAC_BITS);
			pos_y = POS_W'(sy <<< FRAC_BITS);
			points_to_go = (COORD_BITS + 1)'(steps + 1);
			dash_count = '0;
			line_live = 1'b1;
			return;
		end
		if (line_live) begin
			pt.point_valid = 1'b1;
			pt.pixel_x = round_to_pixel(longint'(pos_x));
			pt.pixel_y = round_to_pixel(longint'(pos_y));
			pt.visible = !dash_en_cfg || (dash_count < dash_on_cfg);
			pt.last_point = (points_to_go == 1);
			next_count = {1'b0, dash_count} + 1'b1;
			// A period of zero lets the counter run through all 256 values.
			if (dash_per_cfg != 0 && next_count >= {1'b0, dash_per_cfg})
				next_count = '0;
			dash_count = next_count[DASH_BITS-1:0];
			pos_x = pos_x + inc_x;
			pos_y = pos_y + inc_y;
			points_to_go = points_to_go - 1'b1;
			if (points_to_go == 0)
				line_live = 1'b0;
		end
		expected_points.push_back(pt);
	endfunction

	function automatic int queue_load(input logic [COORD_BITS-1:0] sx, sy, ex, ey);
		item_backlog.push_back('{func: dda_pkg::FUNC_LOAD, start_x: sx, start_y: sy,
			end_x: ex, end_y: ey});
		return 1;
	endfunction

	// Step beats carry random coordinates, which the block must ignore.
	function automatic int queue_steps(input int n);
		for (int i = 0; i < n; i++) begin
			item_backlog.push_back('{func: dda_pkg::FUNC_STEP,
				start_x: COORD_BITS'($urandom), start_y: COORD_BITS'($urandom),
				end_x: COORD_BITS'($urandom), end_y: COORD_BITS'($urandom)});
		end
		return n;
	endfunction

	function automatic logic [COORD_BITS-1:0] near_coord(input logic [COORD_BITS-1:0] base,
			input int reach);
		int b, d, e;
		b = int'($signed(base));
		d = $urandom_range(0, 2 * reach);
		d = d - reach;
		e = b + d;
		if (e > 2047 || e < -2048)
			e = b - d;
		return COORD_BITS'(e);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DASH_BITS-1:0] data);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			dda_pkg::CFG_DASH_ENABLE: dash_en_cfg = data[0];
			dda_pkg::CFG_DASH_PERIOD: dash_per_cfg = data;
			dda_pkg::CFG_DASH_ON_LENGTH: dash_on_cfg = data;
			default: ;
		endcase
	endtask

	// A load gives no result, so the dividers may still be busy once the last
	// point is in; the settle time covers that.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (item_backlog.size() != 0 || item_valid || expected_points.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly complete lines with random endpoints, some cut short by a new
	// load, some long lines only partly walked, and stray step beats.
	task automatic run_phase(input int budget, input int gp, input int sp);
		int used, kind, reach, span;
		logic [COORD_BITS-1:0] sx, sy, ex, ey;
		@(negedge clk);
		gap_pct = gp;
		stall_pct = sp;
		used = 0;
		while (used < budget) begin
			kind = $urandom_range(0, 99);
			sx = COORD_BITS'($urandom);
			sy = COORD_BITS'($urandom);
			if (kind < 60)
				reach = $urandom_range(0, 15);
			else if (kind < 75)
				reach = $urandom_range(0, 40);
			else if (kind < 85)
				reach = $urandom_range(0, 120);
			else
				reach = 2048;
			ex = near_coord(sx, reach);
			ey = near_coord(sy, reach);
			span = line_steps(sx, sy, ex, ey);
			if (kind >= 92) begin
				used += queue_steps($urandom_range(1, 4));
			end else begin
				used += queue_load(sx, sy, ex, ey);
				if (kind < 60 || (kind >= 75 && kind < 85)) begin
					used += queue_steps(span + 1);
					if ($urandom_range(0, 3) == 0)
						used += queue_steps($urandom_range(1, 3));
				end else if (kind < 75) begin
					used += queue_steps($urandom_range(0, span));
				end else begin
					used += queue_steps($urandom_range(1, 20));
				end
			end
		end
		wait_drained();
	endtask

	// Driver: holds a beat until it is taken, then leaves a random gap.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			sender_gap = 0;
		end else begin
			offering = item_valid;
			if (item_valid && !item_stall) begin
				trace_line_item(item);
				offering = 1'b0;
			end
			if (!offering) begin
				if (sender_gap > 0) begin
					sender_gap--;
				end else if (item_backlog.size() != 0) begin
					item <= item_backlog.pop_front();
					offering = 1'b1;
					sender_gap = pick_gap(gap_pct);
				end
			end
			item_valid <= offering;
		end
	end

	// Receiver stall: random short and long holds, plus a requested long hold.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			receiver_hold = 0;
		end else begin
			if (long_hold_req) begin
				receiver_hold = LONG_HOLD_CYCLES;
				long_hold_req = 1'b0;
			end else if (receiver_hold == 0) begin
				receiver_hold = pick_gap(stall_pct);
			end
			result_stall <= (receiver_hold != 0);
			if (receiver_hold != 0)
				receiver_hold--;
		end
	end

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			if (mismatches < REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		dda_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_points.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("%0t: result beat with no point expected, got %p", $time, result);
				mismatches++;
			end else begin
				want = expected_points.pop_front();
				check_field("point_valid", 16'(want.point_valid), 16'(result.point_valid));
				check_field("pixel_x", 16'(want.pixel_x), 16'(result.pixel_x));
				check_field("pixel_y", 16'(want.pixel_y), 16'(result.pixel_y));
				check_field("visible", 16'(want.visible), 16'(result.visible));
				check_field("last_point", 16'(want.last_point), 16'(result.last_point));
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int per;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(dda_pkg::CFG_DASH_ENABLE, 8'd1);

		// Step with no line, a zero-length line, the corners of the coordinate
		// range, a load over a live line and both rounding ties.
		void'(queue_steps(1));
		void'(queue_load(12'h7FF, 12'h800, 12'h7FF, 12'h800));
		void'(queue_steps(2));
		void'(queue_load(12'h800, 12'h800, 12'h7FF, 12'h7FF));
		void'(queue_steps(2));
		void'(queue_load(12'h7FF, 12'h800, 12'h800, 12'h7FF));
		void'(queue_steps(1));
		void'(queue_load(12'd0, 12'd0, 12'd2, 12'd1));
		void'(queue_steps(3));
		void'(queue_load(12'd0, 12'd0, 12'(-2), 12'(-1)));
		void'(queue_steps(3));
		void'(queue_load(12'd0, 12'd0, 12'd20, 12'd5));
		void'(queue_steps(7));
		wait_drained();
		// Lower the period below the dash counter of the line still in flight.
		write_reg(dda_pkg::CFG_DASH_PERIOD, 8'd3);
		void'(queue_steps(3));
		wait_drained();

		write_reg(dda_pkg::CFG_DASH_PERIOD, 8'd1);
		write_reg(dda_pkg::CFG_DASH_ON_LENGTH, 8'd0);
		run_phase(220, 0, 0);

		write_reg(dda_pkg::CFG_DASH_PERIOD, 8'd255);
		write_reg(dda_pkg::CFG_DASH_ON_LENGTH, 8'd255);
		@(negedge clk);
		long_hold_req = 1'b1;
		run_phase(220, 0, 20);

		// Zero period: a 301-point line shows the counter wrap past 255.
		write_reg(dda_pkg::CFG_DASH_PERIOD, 8'd0);
		write_reg(dda_pkg::CFG_DASH_ON_LENGTH, 8'd200);
		void'(queue_load(12'(-150), 12'd40, 12'd150, 12'(-20)));
		void'(queue_steps(301));
		run_phase(120, 20, 20);

		// Only bit 0 of the enable write lands, leaving the line solid.
		write_reg(dda_pkg::CFG_DASH_ENABLE, 8'hFE);
		write_reg(dda_pkg::CFG_DASH_PERIOD, 8'($urandom_range(1, 255)));
		write_reg(dda_pkg::CFG_DASH_ON_LENGTH, 8'($urandom));
		run_phase(220, 50, 50);

		write_reg(dda_pkg::CFG_DASH_ENABLE, 8'h01);
		per = $urandom_range(1, 255);
		write_reg(dda_pkg::CFG_DASH_PERIOD, 8'(per));
		write_reg(dda_pkg::CFG_DASH_ON_LENGTH, 8'($urandom_range(per, 255)));
		run_phase(220, 30, 30);

		per = $urandom_range(2, 20);
		write_reg(dda_pkg::CFG_DASH_PERIOD, 8'(per));
		write_reg(dda_pkg::CFG_DASH_ON_LENGTH, 8'($urandom_range(0, per)));
		write_reg(CFG_UNUSED, 8'($urandom));
		run_phase(220, 10, 60);

		write_reg(dda_pkg::CFG_DASH_PERIOD, 8'($urandom));
		write_reg(dda_pkg::CFG_DASH_ON_LENGTH, 8'($urandom));
		write_reg(dda_pkg::CFG_DASH_ENABLE, 8'($urandom));
		run_phase(220, 60, 10);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> dda_dashed_line_rasterizer.f
hdl/dda_pkg.sv
hdl/dda_div.sv
hdl/dda_ctrl.sv
hdl/dda_dp.sv
hdl/dda_dashed_line_rasterizer.sv
verif/dda_dashed_line_rasterizer_test.sv
